/* rtl/srsc_pkg.sv */
// Shared types and constants for the serial frame receiver with sum check.
`default_nettype none
package srsc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned CFG_IDX_W = 3;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHAR       = 3'd0,
        CFG_END_CHAR         = 3'd1,
        CFG_MAX_BODY_LEN     = 3'd2,
        CFG_ACCEPTED_PRODUCT = 3'd3,
        CFG_LINK_CODE        = 3'd4
    } cfg_idx_t;

    localparam logic [BYTE_W-1:0] START_CHAR_RST       = 8'h2A;
    localparam logic [BYTE_W-1:0] END_CHAR_RST         = 8'h23;
    localparam logic [LEN_W-1:0]  MAX_BODY_LEN_RST     = 6'd49;
    localparam logic [BYTE_W-1:0] ACCEPTED_PRODUCT_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] LINK_CODE_RST        = 8'h02;

    // Body positions of the product and function code bytes
    localparam logic [LEN_W:0] PRODUCT_POS = 7'd1;
    localparam logic [LEN_W:0] CODE_POS    = 7'd7;

    typedef struct packed {
        logic              in_frame;
        logic [LEN_W-1:0]  body_count;
        logic [BYTE_W-1:0] sum_before_prev;
        logic [BYTE_W-1:0] prev_byte;
        logic [BYTE_W-1:0] last_byte;
        logic [BYTE_W-1:0] product_byte;
        logic [BYTE_W-1:0] code_byte;
        logic              link_flag;
    } frame_state_t;

    localparam frame_state_t FRAME_STATE_RST = '0;

endpackage
`default_nettype wire

/* rtl/serial_frame_receiver_sum_check.sv */
// Serial frame receiver: start/end delimited frames with an 8-bit additive checksum.
// An accepted rx_byte beat passes through the input register, then frame logic
//   into the result register, which presents its result beat.
// Throughput: one byte per cycle unless stalled; frame state updates once per byte.
// Reset: rst_n async low; registers return to their defaults, receiver hunts
//   for the start character, link flag cleared, both pipeline stages empty.
`default_nettype none
module serial_frame_receiver_sum_check
(
    input  wire                          clk,
    input  wire                          rst_n,
    // byte input
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [srsc_pkg::BYTE_W-1:0]  rx_byte,
    // result output
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic                         frame_closed,
    output logic                         checksum_ok,
    output logic                         product_match,
    output logic                         link_up,
    // register writes
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [srsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [srsc_pkg::BYTE_W-1:0]  cfg_data
);
    import srsc_pkg::*;

    logic [BYTE_W-1:0] start_char_reg;
    logic [BYTE_W-1:0] end_char_reg;
    logic [LEN_W-1:0]  max_body_len_reg;
    logic [BYTE_W-1:0] accepted_product_reg;
    logic [BYTE_W-1:0] link_code_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    logic              out_valid_reg;
    logic              frame_closed_reg;
    logic              checksum_ok_reg;
    logic              product_match_reg;
    logic              link_up_reg;

    frame_state_t      state_reg;
    frame_state_t      state_next;
    logic              closed_next;
    logic              good_next;
    logic              match_next;

    logic              out_ready;
    logic              s1_adv;
    logic              in_take;

    logic [LEN_W-1:0]  limit;
    logic [LEN_W:0]    cnt;
    logic [BYTE_W-1:0] sum_upd;
    logic [BYTE_W-1:0] product_upd;
    logic [BYTE_W-1:0] code_upd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg       <= START_CHAR_RST;
            end_char_reg         <= END_CHAR_RST;
            max_body_len_reg     <= MAX_BODY_LEN_RST;
            accepted_product_reg <= ACCEPTED_PRODUCT_RST;
            link_code_reg        <= LINK_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_CHAR:       start_char_reg       <= cfg_data;
                CFG_END_CHAR:         end_char_reg         <= cfg_data;
                CFG_MAX_BODY_LEN:     max_body_len_reg     <= cfg_data[LEN_W-1:0];
                CFG_ACCEPTED_PRODUCT: accepted_product_reg <= cfg_data;
                CFG_LINK_CODE:        link_code_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow: result register frees when empty or taken
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Frame logic for the byte in the input register
    always_comb
    begin
        limit       = (max_body_len_reg == '0) ? LEN_W'(1) : max_body_len_reg;
        cnt         = {1'b0, state_reg.body_count} + (LEN_W+1)'(1);
        sum_upd     = state_reg.sum_before_prev + state_reg.prev_byte;
        product_upd = (cnt == PRODUCT_POS) ? s1_byte_reg : state_reg.product_byte;
        code_upd    = (cnt == CODE_POS) ? s1_byte_reg : state_reg.code_byte;
        state_next  = state_reg;
        closed_next = 1'b0;
        good_next   = 1'b0;
        match_next  = 1'b0;

        if (!state_reg.in_frame)
        begin
            if (s1_byte_reg == start_char_reg)
            begin
                state_next           = FRAME_STATE_RST;
                state_next.link_flag = state_reg.link_flag;
                state_next.in_frame  = 1'b1;
                state_next.last_byte = s1_byte_reg;
            end
        end
        else if (s1_byte_reg == end_char_reg || cnt >= {1'b0, limit})
        begin
            closed_next = 1'b1;
            // sum of q0..q(n-2) against q(n-1)
            good_next   = (sum_upd == state_reg.last_byte);
            match_next  = good_next && (product_upd == accepted_product_reg);
            state_next           = FRAME_STATE_RST;
            state_next.link_flag = match_next ? (code_upd == link_code_reg)
                                              : state_reg.link_flag;
        end
        else
        begin
            state_next.body_count      = cnt[LEN_W-1:0];
            state_next.sum_before_prev = sum_upd;
            state_next.prev_byte       = state_reg.last_byte;
            state_next.last_byte       = s1_byte_reg;
            state_next.product_byte    = product_upd;
            state_next.code_byte       = code_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRAME_STATE_RST;
        end
        else if (s1_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            frame_closed_reg  <= closed_next;
            checksum_ok_reg   <= good_next;
            product_match_reg <= match_next;
            link_up_reg       <= state_next.link_flag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_closed  = frame_closed_reg;
    assign checksum_ok   = checksum_ok_reg;
    assign product_match = product_match_reg;
    assign link_up       = link_up_reg;

    // Checks
    a_good_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && checksum_ok_reg |-> frame_closed_reg)
        else $error("checksum_ok without a closed frame");

    a_match_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && product_match_reg |-> checksum_ok_reg)
        else $error("product_match without a good checksum");

    a_hunt_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.in_frame |-> (state_reg.body_count == '0))
        else $error("body count held while hunting");

    a_link_moves_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s1_adv) && (state_reg.link_flag != $past(state_reg.link_flag))
        |-> product_match_reg)
        else $error("link flag changed without a matching frame");

endmodule
`default_nettype wire
